@@ rtl/cbp_pkg.sv @@
// Shared constants, types and helpers for the CAN signal bit-field pack block.
// Used by cbp_cell, cbp_ring and can_signal_bitfield_pack; depends on nothing.
`default_nettype none

package cbp_pkg;

  // Frame size in bytes that take part in a pack or unpack.
  localparam int PAYLOAD_BYTES = 8;
  localparam int BYTE_BITS     = 8;
  localparam int RING_BITS     = 64;
  localparam int IDX_W         = 7;

  // First walk index that lies past the frame.
  localparam logic [IDX_W-1:0] LIMIT = IDX_W'(PAYLOAD_BYTES * BYTE_BITS);
  // Longest field; longer lengths saturate to it.
  localparam logic [IDX_W-1:0] FIELD_MAX = IDX_W'(RING_BITS);
  // Walk end points: an upward walk covers the ring only, a downward walk
  // starts high enough to cover every field that runs past the frame.
  localparam logic [IDX_W-1:0] IDX_RING_TOP = IDX_W'(RING_BITS - 1);
  localparam logic [IDX_W-1:0] IDX_WALK_TOP = '1;
  localparam logic [IDX_W-1:0] IDX_ZERO     = '0;

  // Input tdata layout.
  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 128;

  // Control to the ring of bit cells.
  typedef struct packed {
    logic load;   // take a new payload into the cells
    logic shift;  // move every bit one cell along
    logic up;     // 1: bits move toward cell 0, 0: toward the top cell
  } ring_ctrl_t;

  // Reverses the bit order inside each byte. Applied to a Motorola payload,
  // it turns the field's bit sequence into a run of ascending indexes.
  function automatic logic [RING_BITS-1:0] byte_bit_reverse(input logic [RING_BITS-1:0] d);
    logic [RING_BITS-1:0] r;
    r = '0;
    for (int b = 0; b < RING_BITS / BYTE_BITS; b++) begin
      for (int k = 0; k < BYTE_BITS; k++) begin
        r[b * BYTE_BITS + k] = d[b * BYTE_BITS + (BYTE_BITS - 1 - k)];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/cbp_cell.sv @@
// One bit cell of the payload ring: holds one payload bit and passes it on.
// Depends on cbp_pkg for the ring control struct.
`default_nettype none

module cbp_cell (
  input  wire logic              clk,
  input  wire cbp_pkg::ring_ctrl_t ctrl,
  input  wire logic              load_bit,
  input  wire logic              from_above,
  input  wire logic              from_below,
  output logic                   q
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      q <= load_bit;
    end else if (ctrl.shift) begin
      q <= ctrl.up ? from_above : from_below;
    end
  end

endmodule

`default_nettype wire

@@ rtl/cbp_ring.sv @@
// Ring of 64 bit cells that rotates the payload past its head cell.
// Depends on cbp_pkg and cbp_cell.
`default_nettype none

module cbp_ring (
  input  wire logic                             clk,
  input  wire cbp_pkg::ring_ctrl_t              ctrl,
  input  wire logic [cbp_pkg::RING_BITS-1:0]    load_data,
  input  wire logic                             fb_bit,
  output logic                                  head_bit,
  output logic [cbp_pkg::RING_BITS-1:0]         bits
);

  localparam int N = cbp_pkg::RING_BITS;

  logic [N-1:0] above;
  logic [N-1:0] below;

  // The bit leaving the head comes back, possibly rewritten, at the far end.
  always_comb begin
    above = {fb_bit, bits[N-1:1]};
    below = {bits[N-2:0], fb_bit};
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    cbp_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .load_bit   (load_data[i]),
      .from_above (above[i]),
      .from_below (below[i]),
      .q          (bits[i])
    );
  end

  assign head_bit = ctrl.up ? bits[0] : bits[N-1];

endmodule

`default_nettype wire

@@ rtl/can_signal_bitfield_pack.sv @@
// Top level of the CAN signal bit-field pack and unpack block.
// Depends on cbp_pkg and cbp_ring (which instantiates cbp_cell).
//
// Usage. One input beat on the s_ channel carries a frame payload, the field
// description and, for a set, the value to insert; s_tuser carries the
// command and the byte order. One output beat on the m_ channel returns the
// extracted field and the resulting payload. Every input beat gives exactly
// one output beat, in order.
//
// Operation. The payload sits in a ring of 64 bit cells that rotates one bit
// per cycle past a head cell while the walk index lies on a cell; there the
// field bit is read or rewritten, and a full rotation restores the frame. An
// Intel set and a Motorola get walk the ring upward. An Intel get and a
// Motorola set walk downward from index 127; while the index lies past the
// ring, the ring stands still and the walk only steps through field bits that
// fall past the frame. Each item passes through the walk and finish states,
// where its output beat is registered; no new input beat is taken until idle.
//
// Reset clears the walk control, holds s_tready low and drops any pending
// output beat. When the receiver stalls, the earlier beat waits in the output
// register and the finished result holds in the finish state; once the output
// register is free it takes the result and accepts the next input beat.
`default_nettype none

module can_signal_bitfield_pack (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Input beat tdata, lowest bit up: payload[63:0], start_byte[66:64],
  // start_bit[69:67], field_length[76:70], insert_value[140:77], zeros.
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [cbp_pkg::IN_DATA_W-1:0]   s_tdata,
  // Input beat tuser, lowest bit up: cmd[0], motorola_order[1].
  input  wire logic [1:0]                      s_tuser,
  // Output beat tdata, lowest bit up: field_value[63:0], payload_out[127:64].
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [cbp_pkg::OUT_DATA_W-1:0]       m_tdata
);

  localparam int N  = cbp_pkg::RING_BITS;
  localparam int IW = cbp_pkg::IDX_W;

  typedef enum logic [1:0] {
    IDLE,
    WALK,
    FINISH
  } state_t;

  state_t state;

  // Input fields.
  logic          in_cmd;
  logic          in_moto;
  logic [N-1:0]  in_payload;
  logic [2:0]    in_start_byte;
  logic [2:0]    in_start_bit;
  logic [6:0]    in_length;
  logic [N-1:0]  in_value;

  assign in_cmd        = s_tuser[0];
  assign in_moto       = s_tuser[1];
  assign in_payload    = s_tdata[63:0];
  assign in_start_byte = s_tdata[66:64];
  assign in_start_bit  = s_tdata[69:67];
  assign in_length     = s_tdata[76:70];
  assign in_value      = s_tdata[140:77];

  // Field start as an index into the ring. For Motorola order the ring holds
  // each byte bit-reversed, so the field becomes one ascending run there too.
  logic [5:0]    in_start;
  logic [IW-1:0] in_len_sat;
  logic [IW-1:0] in_end;
  logic          in_up;

  always_comb begin
    in_start   = {in_start_byte, in_moto ? ~in_start_bit : in_start_bit};
    in_len_sat = in_length[6] ? cbp_pkg::FIELD_MAX : in_length;
    in_end     = {1'b0, in_start} + in_len_sat;
    // A get builds the field by shifting left, so it has to meet the field's
    // top bit first; a set consumes the value from its low end.
    in_up      = in_cmd ^ in_moto;
  end

  logic accept;
  logic out_load;
  assign s_tready = (state == IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;
  // The finished result moves into the output register once it is free.
  assign out_load = (state == FINISH) && (!m_tvalid || m_tready);

  // Walk registers.
  logic [IW-1:0] idx;
  logic [5:0]    win_lo;
  logic [IW-1:0] win_hi;
  logic          cmd_q;
  logic          moto_q;
  logic          up_q;
  logic [N-1:0]  field_acc;
  logic [N-1:0]  value_sr;

  // Ring of cells.
  cbp_pkg::ring_ctrl_t ring_ctrl;
  logic                head_bit;
  logic                fb_bit;
  logic [N-1:0]        ring_bits;
  logic [N-1:0]        ring_load;

  logic in_win;
  logic in_frame;
  logic walk_last;

  always_comb begin
    in_win    = (idx >= {1'b0, win_lo}) && (idx < win_hi);
    in_frame  = (idx < cbp_pkg::LIMIT);
    walk_last = up_q ? (idx == cbp_pkg::IDX_RING_TOP) : (idx == cbp_pkg::IDX_ZERO);
    // A set rewrites the head bit with the next value bit inside the field and
    // the frame; anything else sends the bit around unchanged.
    fb_bit    = (cmd_q && in_win && in_frame) ? value_sr[0] : head_bit;
    ring_load = in_moto ? cbp_pkg::byte_bit_reverse(in_payload) : in_payload;

    ring_ctrl.load  = accept;
    // The ring moves only while the walk index lies on a real cell.
    ring_ctrl.shift = (state == WALK) && !idx[IW-1];
    ring_ctrl.up    = up_q;
  end

  cbp_ring u_ring (
    .clk       (clk),
    .ctrl      (ring_ctrl),
    .load_data (ring_load),
    .fb_bit    (fb_bit),
    .head_bit  (head_bit),
    .bits      (ring_bits)
  );

  logic [N-1:0] result_payload;
  logic [N-1:0] result_field;

  always_comb begin
    result_payload = moto_q ? cbp_pkg::byte_bit_reverse(ring_bits) : ring_bits;
    result_field   = cmd_q ? '0 : field_acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            idx       <= in_up ? cbp_pkg::IDX_ZERO : cbp_pkg::IDX_WALK_TOP;
            win_lo    <= in_start;
            win_hi    <= in_end;
            cmd_q     <= in_cmd;
            moto_q    <= in_moto;
            up_q      <= in_up;
            field_acc <= '0;
            value_sr  <= in_value;
            state     <= WALK;
          end
        end
        WALK: begin
          if (in_win) begin
            // Every field step uses one value bit, even past the frame, so
            // the bits that do land in the frame line up.
            value_sr <= value_sr >> 1;
            if (in_frame && !cmd_q) begin
              field_acc <= {field_acc[N-2:0], head_bit};
            end
          end
          if (walk_last) begin
            state <= FINISH;
          end else begin
            idx <= up_q ? idx + 1'b1 : idx - 1'b1;
          end
        end
        FINISH: begin
          if (out_load) begin
            m_tdata  <= {result_payload, result_field};
            m_tvalid <= 1'b1;
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // An output beat appears only out of the finish state.
  a_valid_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == FINISH))
    else $error("output beat raised outside the finish state");

  // An upward walk never leaves the ring.
  a_up_walk_in_ring: assert property (@(posedge clk) disable iff (rst)
    (state == WALK && up_q) |-> !idx[IW-1])
    else $error("upward walk index past the ring");

  // A new input beat starts a walk, so no result can follow it at once.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == WALK) && !$rose(m_tvalid))
    else $error("result appeared right after an accepted input beat");

endmodule

`default_nettype wire

@@ verif/can_signal_bitfield_pack_tb.sv @@
// Self-checking testbench for the CAN signal bit-field pack and unpack block.
// Needs cbp_pkg and the can_signal_bitfield_pack RTL; reads no files.
`timescale 1ns / 100ps

module can_signal_bitfield_pack_tb;

  // Command and byte order codes as they travel in s_tuser.
  localparam logic CMD_GET        = 1'b0;
  localparam logic CMD_SET        = 1'b1;
  localparam logic ORDER_INTEL    = 1'b0;
  localparam logic ORDER_MOTOROLA = 1'b1;

  // Bits of the frame that a field may touch; higher bits pass through.
  localparam int FRAME_BITS = (cbp_pkg::PAYLOAD_BYTES * 8 > 64) ? 64 :
                              cbp_pkg::PAYLOAD_BYTES * 8;
  // Extra cycles allowed after the last result.
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    logic        cmd;
    logic        order;
    logic [63:0] payload;
    logic [2:0]  start_byte;
    logic [2:0]  start_bit;
    logic [6:0]  field_length;
    logic [63:0] insert_value;
  } signal_req_t;

  typedef struct {
    logic [63:0] field_value;
    logic [63:0] payload_out;
  } signal_res_t;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [cbp_pkg::IN_DATA_W-1:0]  s_tdata;
  logic [1:0]                     s_tuser;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [cbp_pkg::OUT_DATA_W-1:0] m_tdata;

  // Results the block still owes, oldest first.
  signal_res_t pending_results[$];

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int frames_sent   = 0;
  int gets_sent     = 0;
  int motorola_sent = 0;
  int trunc_sent    = 0;
  int results_seen  = 0;
  int error_count   = 0;

  can_signal_bitfield_pack dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Walks the field one bit at a time, as a signal database defines it.
  // Intel fields climb from their LSB. Motorola fields start at their MSB,
  // step down inside a byte and then jump to bit 7 of the next byte. Bits
  // that would land past the frame end the walk, so a truncated Motorola
  // field keeps only its top bits.
  function automatic signal_res_t predict_signal(input signal_req_t r);
    signal_res_t res;
    logic [63:0] fld;
    logic [63:0] pl;
    int unsigned pos;
    int unsigned len;
    int unsigned j;
    fld = '0;
    pl  = r.payload;
    pos = r.start_byte * 8 + r.start_bit;
    len = (r.field_length > 64) ? 64 : r.field_length;
    for (j = 0; j < len && pos < FRAME_BITS; j++) begin
      if (r.order == ORDER_MOTOROLA) begin
        if (r.cmd == CMD_GET) fld = {fld[62:0], r.payload[pos]};
        else pl[pos] = r.insert_value[len - 1 - j];
        if (pos % 8 == 0) pos += 15;
        else pos -= 1;
      end else begin
        if (r.cmd == CMD_GET) fld[j] = r.payload[pos];
        else pl[pos] = r.insert_value[j];
        pos += 1;
      end
    end
    res.field_value = (r.cmd == CMD_GET) ? fld : 64'd0;
    res.payload_out = (r.cmd == CMD_GET) ? r.payload : pl;
    return res;
  endfunction

  function automatic signal_req_t make_req(input logic cmd, input logic order,
                                           input int sbyte, input int sbit,
                                           input int len, input logic [63:0] payload,
                                           input logic [63:0] value);
    signal_req_t r;
    r.cmd          = cmd;
    r.order        = order;
    r.start_byte   = sbyte[2:0];
    r.start_bit    = sbit[2:0];
    r.field_length = len[6:0];
    r.payload      = payload;
    r.insert_value = value;
    return r;
  endfunction

  // Sends one beat. Entered and left at a falling edge; tvalid is low only
  // while the source idles, so back-to-back beats keep it high.
  task automatic send_signal(input signal_req_t r);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, r.insert_value, r.field_length, r.start_bit, r.start_byte,
                 r.payload};
    s_tuser  <= {r.order, r.cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(predict_signal(r));
    frames_sent++;
    if (r.cmd == CMD_GET) gets_sent++;
    if (r.order == ORDER_MOTOROLA) motorola_sent++;
    if (r.field_length != 0 && (r.start_byte * 8 + r.start_bit + r.field_length > 64 ||
        r.order == ORDER_MOTOROLA)) trunc_sent++;
    @(negedge clk);
  endtask

  // Corner cases: full-width fields in both orders, zero and oversized
  // lengths, fields that run off the end of the frame, single-bit fields at
  // both frame ends and the Motorola jump from bit 0 to the next byte.
  task automatic test_directed_corners();
    logic [63:0] pat;
    pat = 64'hA55A_3CC3_0FF0_9669;
    send_signal(make_req(CMD_GET, ORDER_INTEL,    0, 0, 64, pat, '0));
    send_signal(make_req(CMD_SET, ORDER_INTEL,    0, 0, 64, '0, '1));
    send_signal(make_req(CMD_SET, ORDER_INTEL,    0, 0, 64, '1, '0));
    send_signal(make_req(CMD_GET, ORDER_MOTOROLA, 0, 7, 64, pat, '0));
    send_signal(make_req(CMD_SET, ORDER_MOTOROLA, 0, 7, 64, '0, pat));
    send_signal(make_req(CMD_GET, ORDER_INTEL,    3, 5, 0, pat, '1));
    send_signal(make_req(CMD_SET, ORDER_MOTOROLA, 3, 5, 0, pat, '1));
    send_signal(make_req(CMD_GET, ORDER_INTEL,    0, 0, 127, '1, '0));
    send_signal(make_req(CMD_SET, ORDER_MOTOROLA, 0, 7, 65, '0, '1));
    send_signal(make_req(CMD_SET, ORDER_INTEL,    2, 1, 100, pat, ~pat));
    send_signal(make_req(CMD_GET, ORDER_INTEL,    7, 4, 12, pat, '0));
    send_signal(make_req(CMD_SET, ORDER_INTEL,    7, 4, 12, '0, '1));
    send_signal(make_req(CMD_GET, ORDER_MOTOROLA, 6, 3, 20, pat, '0));
    send_signal(make_req(CMD_SET, ORDER_MOTOROLA, 6, 3, 20, '0, 64'h000F_5A5A));
    send_signal(make_req(CMD_GET, ORDER_MOTOROLA, 7, 0, 64, '1, '0));
    send_signal(make_req(CMD_GET, ORDER_INTEL,    0, 0, 1, 64'h1, '0));
    send_signal(make_req(CMD_SET, ORDER_INTEL,    7, 7, 1, '0, 64'h1));
    send_signal(make_req(CMD_SET, ORDER_MOTOROLA, 7, 7, 1, '1, 64'h0));
    send_signal(make_req(CMD_GET, ORDER_MOTOROLA, 2, 0, 10, pat, '0));
    send_signal(make_req(CMD_SET, ORDER_MOTOROLA, 2, 0, 10, pat, 64'h2A5));
    send_signal(make_req(CMD_SET, ORDER_INTEL,    1, 3, 13, '1, 64'hFFFF_FFFF_FFFF_E000));
  endtask

  // Random signals over the whole field space. Lengths lean toward typical
  // signal sizes, with zero, full-width and oversized lengths mixed in.
  task automatic run_random_signals(input int count);
    signal_req_t r;
    int sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      r.cmd          = 1'($urandom_range(0, 1));
      r.order        = 1'($urandom_range(0, 1));
      r.payload      = {$urandom, $urandom};
      r.insert_value = {$urandom, $urandom};
      r.start_byte   = 3'($urandom_range(0, 7));
      r.start_bit    = 3'($urandom_range(0, 7));
      if (sel < 8) r.field_length = 7'd0;
      else if (sel < 45) r.field_length = 7'($urandom_range(1, 16));
      else if (sel < 80) r.field_length = 7'($urandom_range(17, 63));
      else if (sel < 92) r.field_length = 7'd64;
      else r.field_length = 7'($urandom_range(65, 127));
      send_signal(r);
    end
  endtask

  task automatic test_sink_backpressure();
    src_idle_pct  = 6;
    sink_idle_pct = 80;
    run_random_signals(300);
  endtask

  task automatic test_source_gaps();
    src_idle_pct  = 80;
    sink_idle_pct = 6;
    run_random_signals(300);
  endtask

  task automatic test_full_rate();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_random_signals(300);
  endtask

  // The receiver stalls at random, redrawn every cycle.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // Every accepted output beat is matched against the oldest prediction.
  always @(posedge clk) begin : check_results
    signal_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected output beat, field_value=%h payload_out=%h",
                 $time, m_tdata[63:0], m_tdata[127:64]);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[63:0] !== want.field_value) begin
          $display("%0t: field_value mismatch, expected %h actual %h",
                   $time, want.field_value, m_tdata[63:0]);
          error_count++;
        end
        if (m_tdata[127:64] !== want.payload_out) begin
          $display("%0t: payload_out mismatch, expected %h actual %h",
                   $time, want.payload_out, m_tdata[127:64]);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    m_tready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_corners();
    test_sink_backpressure();
    test_source_gaps();
    test_full_rate();
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d signals: %0d gets, %0d sets, %0d in Motorola order, %0d at risk",
             frames_sent, gets_sent, frames_sent - gets_sent, motorola_sent, trunc_sent);
    $display("of running off the frame; %0d output beats checked, %0d errors.",
             results_seen, error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: stops a run that hangs and reports the results still outstanding.
  initial begin
    #20_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ can_signal_bitfield_pack.f @@
rtl/cbp_pkg.sv
rtl/cbp_cell.sv
rtl/cbp_ring.sv
rtl/can_signal_bitfield_pack.sv
verif/can_signal_bitfield_pack_tb.sv
